/* design/queue_with_running_max_macros.svh */
// Assertion helpers for the queue design.
`ifndef QUEUE_WITH_RUNNING_MAX_MACROS_SVH
`define QUEUE_WITH_RUNNING_MAX_MACROS_SVH

// Implication check, sampled on clk and held off during reset.
`define QRM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold on a clock edge.
`define QRM_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/qrm_pkg.sv */
package qrm_pkg;

    // Operation select on the input channel
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

/* design/queue_with_running_max.sv */
// Channel | Handshake            | Beat fields
// --------+----------------------+------------------------------------------
// in      | in_valid / in_stall  | mode, value
// out     | out_valid / out_stall| max_value, max_valid, occupancy, status
//
// A pop that moves the helper deque front refetches the new front from its
// RAM when entries remain. A push to a full queue or an empty deque completes
// without a RAM read; otherwise it examines deque entries from the back, one
// RAM read each, until it finds a larger one or the deque is drained.
// Reset clears all counters and pointers at once; no RAM sweep is needed.
// A finished beat waits in the output register; the next input beat is taken
// as soon as that register can be loaded.
module queue_with_running_max #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic signed [DATA_WIDTH-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  max_value,
    output logic                          max_valid,
    output logic [$clog2(DEPTH+1)-1:0]    occupancy,
    output logic [1:0]                    status
);

    import qrm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(2 * DEPTH);
    localparam int EW = TW + DATA_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REFILL
    } state_t;

    // Helper deque entry: tag above value
    typedef struct packed {
        logic [TW-1:0]         tag;
        logic [DATA_WIDTH-1:0] val;
    } peak_entry_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         value_count_reg, value_count_next;
    logic [AW-1:0]         peak_head_reg, peak_head_next;
    logic [CW-1:0]         peak_count_reg, peak_count_next;
    logic [TW-1:0]         next_tag_reg, next_tag_next;
    logic [DATA_WIDTH-1:0] front_val_reg, front_val_next;
    logic [TW-1:0]         front_tag_reg, front_tag_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [1:0]            status_reg, status_next;
    logic                  res_pend_reg, res_pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] max_value_reg, max_value_next;
    logic                  max_valid_reg, max_valid_next;
    logic [CW-1:0]         occupancy_reg, occupancy_next;
    logic [1:0]            out_status_reg, out_status_next;

    logic                  out_free;
    logic                  load_out;
    logic                  accept;
    logic                  q_nonempty;
    logic [TW:0]           tag_sum;
    logic [TW-1:0]         data_front_tag;
    logic [TW-1:0]         tag_inc;
    logic [CW-1:0]         cnt_dec;
    logic [AW-1:0]         head_inc;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    peak_entry_t           rd_entry;
    logic [EW-1:0]         rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    peak_entry_t           wr_entry;

    // Ring index: head plus offset, wrapped once at DEPTH
    function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Helper deque storage
    qrm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_peak_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = peak_entry_t'(rd_data);

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = res_pend_reg && out_free;
    assign in_stall = !((state_reg == ST_IDLE) && (!res_pend_reg || out_free));
    assign accept   = in_valid && !in_stall;

    // Tag of the data front: next_tag - count, modulo 2*DEPTH
    assign tag_sum = (TW+1)'(next_tag_reg) + (TW+1)'(2 * DEPTH)
                   - (TW+1)'(value_count_reg);
    assign data_front_tag = (tag_sum >= (TW+1)'(2 * DEPTH))
                          ? TW'(tag_sum - (TW+1)'(2 * DEPTH)) : tag_sum[TW-1:0];
    assign tag_inc = (next_tag_reg == TW'(2 * DEPTH - 1)) ? '0 : next_tag_reg + 1'b1;

    assign cnt_dec    = peak_count_reg - 1'b1;
    assign head_inc   = ring_at(peak_head_reg, CW'(1));
    assign q_nonempty = (value_count_reg != '0) && (peak_count_reg != '0);

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        value_count_next = value_count_reg;
        peak_head_next   = peak_head_reg;
        peak_count_next  = peak_count_reg;
        next_tag_next    = next_tag_reg;
        front_val_next   = front_val_reg;
        front_tag_next   = front_tag_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        res_pend_next    = res_pend_reg;
        out_valid_next   = out_valid_reg;
        max_value_next   = max_value_reg;
        max_valid_next   = max_valid_reg;
        occupancy_next   = occupancy_reg;
        out_status_next  = out_status_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_entry.tag     = next_tag_reg;
        wr_entry.val     = value_reg;

        // Output register: load the finished beat or drain
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            max_valid_next  = q_nonempty;
            max_value_next  = q_nonempty ? front_val_reg : '0;
            occupancy_next  = value_count_reg;
            out_status_next = status_reg;
            res_pend_next   = 1'b0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next = value;
                    if (mode == MODE_PUSH)
                    begin
                        if (value_count_reg == CW'(DEPTH))
                        begin
                            status_next   = STATUS_FULL;
                            res_pend_next = 1'b1;
                        end
                        else if (peak_count_reg == '0)
                        begin
                            // Empty deque: new value becomes the front
                            wr_en            = 1'b1;
                            wr_addr          = peak_head_reg;
                            wr_entry.val     = value;
                            front_val_next   = value;
                            front_tag_next   = next_tag_reg;
                            peak_count_next  = CW'(1);
                            value_count_next = value_count_reg + 1'b1;
                            next_tag_next    = tag_inc;
                            status_next      = STATUS_OK;
                            res_pend_next    = 1'b1;
                        end
                        else
                        begin
                            // Fetch the deque back entry
                            rd_en      = 1'b1;
                            rd_addr    = ring_at(peak_head_reg, cnt_dec);
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (value_count_reg == '0)
                        begin
                            status_next   = STATUS_EMPTY;
                            res_pend_next = 1'b1;
                        end
                        else
                        begin
                            value_count_next = value_count_reg - 1'b1;
                            status_next      = STATUS_OK;
                            if (peak_count_reg != '0 && front_tag_reg == data_front_tag)
                            begin
                                peak_head_next  = head_inc;
                                peak_count_next = cnt_dec;
                                if (cnt_dec != '0)
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = head_inc;
                                    state_next = ST_REFILL;
                                end
                                else
                                begin
                                    res_pend_next = 1'b1;
                                end
                            end
                            else
                            begin
                                res_pend_next = 1'b1;
                            end
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if ($signed(rd_entry.val) <= $signed(value_reg))
                begin
                    // Back entry is dominated: drop it
                    peak_count_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = peak_head_reg;
                        front_val_next   = value_reg;
                        front_tag_next   = next_tag_reg;
                        peak_count_next  = CW'(1);
                        value_count_next = value_count_reg + 1'b1;
                        next_tag_next    = tag_inc;
                        status_next      = STATUS_OK;
                        res_pend_next    = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ring_at(peak_head_reg, cnt_dec - 1'b1);
                    end
                end
                else
                begin
                    // Append behind the larger entry
                    wr_en            = 1'b1;
                    wr_addr          = ring_at(peak_head_reg, peak_count_reg);
                    peak_count_next  = peak_count_reg + 1'b1;
                    value_count_next = value_count_reg + 1'b1;
                    next_tag_next    = tag_inc;
                    status_next      = STATUS_OK;
                    res_pend_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_REFILL:
            begin
                // New deque front arrives from the RAM
                front_val_next = rd_entry.val;
                front_tag_next = rd_entry.tag;
                res_pend_next  = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            value_count_reg <= '0;
            peak_head_reg   <= '0;
            peak_count_reg  <= '0;
            next_tag_reg    <= '0;
            front_val_reg   <= '0;
            front_tag_reg   <= '0;
            value_reg       <= '0;
            status_reg      <= STATUS_OK;
            res_pend_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            max_value_reg   <= '0;
            max_valid_reg   <= 1'b0;
            occupancy_reg   <= '0;
            out_status_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg       <= state_next;
            value_count_reg <= value_count_next;
            peak_head_reg   <= peak_head_next;
            peak_count_reg  <= peak_count_next;
            next_tag_reg    <= next_tag_next;
            front_val_reg   <= front_val_next;
            front_tag_reg   <= front_tag_next;
            value_reg       <= value_next;
            status_reg      <= status_next;
            res_pend_reg    <= res_pend_next;
            out_valid_reg   <= out_valid_next;
            max_value_reg   <= max_value_next;
            max_valid_reg   <= max_valid_next;
            occupancy_reg   <= occupancy_next;
            out_status_reg  <= out_status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_value = max_value_reg;
    assign max_valid = max_valid_reg;
    assign occupancy = occupancy_reg;
    assign status    = out_status_reg;

    // Checks
`include "queue_with_running_max_macros.svh"

    `QRM_ASSERT_NEVER(a_peak_le_data, peak_count_reg > value_count_reg, "deque longer than queue")
    `QRM_ASSERT_NEVER(a_count_bound, value_count_reg > CW'(DEPTH), "queue count above depth")
    `QRM_ASSERT_IMP(a_front_present, value_count_reg != '0, peak_count_reg != '0, "queue holds data but deque is empty")
    `QRM_ASSERT_IMP(a_no_accept_busy, res_pend_reg && !out_free, in_stall, "beat taken while a result is blocked")

endmodule

/* design/qrm_ram.sv */
module qrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
